// ----- rtl/hs_pkg.sv -----
// ----------------------------------------------------------------------------
// hs_pkg
// Shared types and constants of the heap sorter: payload structs, data type
// and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package hs_pkg;

	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 64;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		data_t value;
		logic  last_in;
	} item_t;

	typedef struct packed {
		data_t sorted_value;
		logic  last_out;
		logic  overflow;
	} result_t;

	typedef enum logic [3:0] {
		S_LOAD,
		S_NEXT,
		S_CUR,
		S_EXT_LAST,
		S_EXT_SWAP,
		S_L,
		S_R,
		S_CMP,
		S_OUT_RD,
		S_OUT_WR
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/hs_ram.sv -----
// ----------------------------------------------------------------------------
// hs_ram
// Simple dual-port store: one write and one read per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hs_ram #(
	parameter int DEPTH = hs_pkg::CAPACITY_DEF
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire  [$clog2(DEPTH)-1:0]  waddr,
	input  wire  hs_pkg::data_t       wdata,
	input  wire                       re,
	input  wire  [$clog2(DEPTH)-1:0]  raddr,
	output hs_pkg::data_t             rdata
);

	hs_pkg::data_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/heap_sorter_unit.sv -----
// ----------------------------------------------------------------------------
// heap_sorter_unit
// Min-heap heapsort over a set of signed 32-bit values held in one RAM.
// ----------------------------------------------------------------------------
// Items are taken one per cycle and written to the store in arrival order;
// the item with last_in closes the set, and items beyond CAPACITY are dropped
// (overflow is then set on every result of that set). After the last item the
// block sorts in place and takes no further request until the set has been
// streamed out in ascending order. All work goes through the single read port
// of the store: each sift level reads the left child, reads the right child,
// then compares and writes back; each extraction first reads the root and the
// tail and writes the old root to the tail; each result is read and then
// registered, and waits while a pending result has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sorter_unit #(
	parameter int CAPACITY = hs_pkg::CAPACITY_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	input  wire hs_pkg::item_t  item,
	output logic                result_valid,
	input  wire                 result_ready,
	output hs_pkg::result_t     result
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = AW + 2;

	hs_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q, size_q, build_q, ext_q;
	logic             dropped_q;
	logic [AW-1:0]    pos_q, out_addr_q;
	hs_pkg::data_t    cur_q, lval_q, root_q;
	logic             result_valid_q;
	hs_pkg::result_t  result_q;

	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	hs_pkg::data_t    mem_wdata, mem_rdata;

	logic             item_acc, full;
	logic [CNT_W-1:0] n_now;
	logic [CW-1:0]    l_idx, r_idx, size_ext;
	logic             l_ok, r_ok, l_better, r_better, move;
	hs_pkg::data_t    best_val, child_val;
	logic [CW-1:0]    child_idx;

	hs_ram #(.DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign full     = (cnt_q == CNT_W'(CAPACITY));
	assign n_now    = cnt_q + CNT_W'(!full);
	assign item_acc = item_valid && item_ready;

	// children of the hole; right index may reach 2*CAPACITY
	assign l_idx    = {1'b0, pos_q, 1'b1};
	assign r_idx    = l_idx + CW'(1);
	assign size_ext = CW'(size_q);
	assign l_ok     = (l_idx < size_ext);
	assign r_ok     = (r_idx < size_ext);

	// right data is on the read port in S_CMP
	assign l_better  = (lval_q < cur_q);
	assign best_val  = l_better ? lval_q : cur_q;
	assign r_better  = r_ok && (mem_rdata < best_val);
	assign move      = l_better || r_better;
	assign child_val = r_better ? mem_rdata : lval_q;
	assign child_idx = r_better ? r_idx : l_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hs_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = pos_q;
		mem_wdata  = cur_q;
		mem_re     = 1'b0;
		mem_raddr  = pos_q;
		unique case (state_q)
			hs_pkg::S_LOAD: begin
				item_ready = 1'b1;
				if (item_valid) begin
					mem_we    = !full;
					mem_waddr = cnt_q[AW-1:0];
					mem_wdata = item.value;
					if (item.last_in) begin
						state_d = hs_pkg::S_NEXT;
					end
				end
			end
			hs_pkg::S_NEXT: begin
				if (build_q != '0) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(build_q - CNT_W'(1));
					state_d   = hs_pkg::S_CUR;
				end else if (ext_q >= CNT_W'(2)) begin
					mem_re    = 1'b1;
					mem_raddr = '0;
					state_d   = hs_pkg::S_EXT_LAST;
				end else begin
					state_d = hs_pkg::S_OUT_RD;
				end
			end
			hs_pkg::S_CUR: begin
				state_d = hs_pkg::S_L;
			end
			hs_pkg::S_EXT_LAST: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(ext_q - CNT_W'(1));
				state_d   = hs_pkg::S_EXT_SWAP;
			end
			hs_pkg::S_EXT_SWAP: begin
				// old root goes to the tail, tail value sinks from the root
				mem_we    = 1'b1;
				mem_waddr = AW'(ext_q - CNT_W'(1));
				mem_wdata = root_q;
				state_d   = hs_pkg::S_L;
			end
			hs_pkg::S_L: begin
				if (l_ok) begin
					mem_re    = 1'b1;
					mem_raddr = l_idx[AW-1:0];
					state_d   = hs_pkg::S_R;
				end else begin
					mem_we  = 1'b1;
					state_d = hs_pkg::S_NEXT;
				end
			end
			hs_pkg::S_R: begin
				mem_re    = r_ok;
				mem_raddr = r_idx[AW-1:0];
				state_d   = hs_pkg::S_CMP;
			end
			hs_pkg::S_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = move ? child_val : cur_q;
				state_d   = move ? hs_pkg::S_L : hs_pkg::S_NEXT;
			end
			hs_pkg::S_OUT_RD: begin
				if (!result_valid_q || result_ready) begin
					mem_re    = 1'b1;
					mem_raddr = out_addr_q;
					state_d   = hs_pkg::S_OUT_WR;
				end
			end
			hs_pkg::S_OUT_WR: begin
				state_d = (out_addr_q == '0) ? hs_pkg::S_LOAD : hs_pkg::S_OUT_RD;
			end
			default: begin
				state_d = hs_pkg::S_LOAD;
			end
		endcase
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			size_q         <= '0;
			build_q        <= '0;
			ext_q          <= '0;
			dropped_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == hs_pkg::S_OUT_WR) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				hs_pkg::S_LOAD: begin
					if (item_acc) begin
						cnt_q     <= n_now;
						dropped_q <= dropped_q || full;
						if (item.last_in) begin
							build_q <= n_now >> 1;
							ext_q   <= n_now;
						end
					end
				end
				hs_pkg::S_NEXT: begin
					if (build_q != '0) begin
						build_q <= build_q - CNT_W'(1);
						size_q  <= cnt_q;
					end
				end
				hs_pkg::S_EXT_SWAP: begin
					size_q <= ext_q - CNT_W'(1);
					ext_q  <= ext_q - CNT_W'(1);
				end
				hs_pkg::S_OUT_WR: begin
					if (out_addr_q == '0) begin
						cnt_q     <= '0;
						size_q    <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			hs_pkg::S_NEXT: begin
				if (build_q != '0) begin
					pos_q <= AW'(build_q - CNT_W'(1));
				end else begin
					out_addr_q <= AW'(cnt_q - CNT_W'(1));
				end
			end
			hs_pkg::S_CUR: begin
				cur_q <= mem_rdata;
			end
			hs_pkg::S_EXT_LAST: begin
				root_q <= mem_rdata;
			end
			hs_pkg::S_EXT_SWAP: begin
				cur_q <= mem_rdata;
				pos_q <= '0;
			end
			hs_pkg::S_R: begin
				lval_q <= mem_rdata;
			end
			hs_pkg::S_CMP: begin
				if (move) begin
					pos_q <= child_idx[AW-1:0];
				end
			end
			hs_pkg::S_OUT_WR: begin
				result_q.sorted_value <= mem_rdata;
				result_q.last_out     <= (out_addr_q == '0);
				result_q.overflow     <= dropped_q;
				out_addr_q            <= out_addr_q - AW'(1);
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("store read and write hit the same entry");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == hs_pkg::S_OUT_WR))
		else $error("result raised outside the output pass");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("element count beyond capacity");

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= cnt_q)
		else $error("heap size exceeds element count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hs_pkg::S_OUT_WR) |-> (!result_valid_q || result_ready))
		else $error("pending result overwritten");

endmodule

`default_nettype wire
